>>> src/utf8_to_utf16_validating_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_VALIDATING_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_VALIDATING_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define U2U_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u2u: same-cycle check failed");

// next-cycle implication
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u2u: next-cycle check failed");

`endif

>>> src/u2u_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Widths, code points, status codes and register map of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;
	localparam int LIMIT_W    = 17;
	localparam int UNITS_W    = 17;
	localparam int SCALAR_W   = 21;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_OVERSIZED = 2'd2
	} status_t;

	localparam logic [0:0] REG_UNIT_LIMIT = 1'b0;

	localparam logic [LIMIT_W-1:0] UNIT_LIMIT_RESET = 17'h10000;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD2_MAX  = 8'hDF;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD3_MAX  = 8'hEF;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_MARK  = 8'h80;

	localparam logic [SCALAR_W-1:0] MIN_3BYTE  = 21'h000800;
	localparam logic [SCALAR_W-1:0] MIN_4BYTE  = 21'h010000;
	localparam logic [SCALAR_W-1:0] BMP_MAX    = 21'h00FFFF;
	localparam logic [SCALAR_W-1:0] SURR_MIN   = 21'h00D800;
	localparam logic [SCALAR_W-1:0] SURR_MAX   = 21'h00DFFF;
	localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10FFFF;

	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

endpackage

`default_nettype wire

>>> src/utf8_to_utf16_validating_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 validating decoder
// Streams UTF-8 bytes in, emits UTF-16 units or surrogate pairs with status.
// ----------------------------------------------------------------------------
// Input stream s_*: one UTF-8 byte per transaction in s_tdata[7:0], s_tlast
// on the last byte of a stream. Output stream m_*: one transaction per
// valid scalar within the limit or per last byte, m_tlast marking the latter,
// whose status is the verdict on the whole stream (0 ok, 1 invalid,
// 2 oversized). After the first error no more units leave until the end.
// A byte passes an input register, then the decode and state update into
// the output register. The block takes one byte per cycle unless a result
// must wait for a stalled output. The input register keeps accepting while
// a result waits; when m_tready is low and a new result is due, s_tready
// drops until the output register drains. Bytes that make no result never
// stall. Reset clears the stream state and sets unit_limit to 65536.
// unit_limit sits at APB byte address 0 and should be written only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_validating_decoder_top
	import u2u_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] byte_value
	input  wire logic                  s_tlast,   // final_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // [1:0] unit_count, [17:2] first_unit,
	                                              // [33:18] second_unit, [35:34] status
	output logic                       m_tlast,   // end_of_stream
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	logic [7:0]          byte_s1;
	logic                final_s1;
	logic                valid_s1;

	logic [1:0]          pend_q, pend_d;
	logic [2:0]          seqlen_q, seqlen_d;
	logic [SCALAR_W-1:0] acc_q, acc_d;
	logic                invalid_q, invalid_d;
	logic                oversize_q, oversize_d;
	logic [UNITS_W-1:0]  units_q, units_d;
	logic [LIMIT_W-1:0]  limit_q;

	logic                m_valid_q;
	logic [1:0]          count_q;
	logic [15:0]         unit0_q, unit1_q;
	status_t             status_q;
	logic                last_q;

	logic                done;
	logic [1:0]          n_units, k_units;
	logic [15:0]         u0, u1;
	logic [SCALAR_W-1:0] scalar, vdiff;
	logic [UNITS_W:0]    sum;
	status_t             status_d;
	logic                has_res, consume, out_free, cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_UNIT_LIMIT);
	assign prdata   = (paddr[2] == REG_UNIT_LIMIT) ?
		{{(CFG_DATA_W-LIMIT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= UNIT_LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		pend_d     = pend_q;
		seqlen_d   = seqlen_q;
		acc_d      = acc_q;
		invalid_d  = invalid_q;
		oversize_d = oversize_q;
		units_d    = units_q;
		done       = 1'b0;
		n_units    = 2'd0;
		k_units    = 2'd0;
		u0         = 16'd0;
		u1         = 16'd0;
		scalar     = '0;
		vdiff      = '0;
		sum        = '0;
		status_d   = ST_OK;
		if (!invalid_q && !oversize_q) begin
			if (pend_q == 2'd0) begin
				priority if (byte_s1 <= ASCII_MAX) begin
					acc_d    = {13'd0, byte_s1};
					seqlen_d = 3'd1;
					done     = 1'b1;
				end else if (byte_s1 >= LEAD2_MIN && byte_s1 <= LEAD2_MAX) begin
					acc_d    = {16'd0, byte_s1[4:0]};
					seqlen_d = 3'd2;
					pend_d   = 2'd1;
				end else if (byte_s1 >= LEAD3_MIN && byte_s1 <= LEAD3_MAX) begin
					acc_d    = {17'd0, byte_s1[3:0]};
					seqlen_d = 3'd3;
					pend_d   = 2'd2;
				end else if (byte_s1 >= LEAD4_MIN && byte_s1 <= LEAD4_MAX) begin
					acc_d    = {18'd0, byte_s1[2:0]};
					seqlen_d = 3'd4;
					pend_d   = 2'd3;
				end else begin
					invalid_d = 1'b1;
				end
			end else if ((byte_s1 & CONT_MASK) != CONT_MARK) begin
				invalid_d = 1'b1;
			end else begin
				acc_d  = {acc_q[SCALAR_W-7:0], byte_s1[5:0]};
				pend_d = pend_q - 2'd1;
				done   = (pend_q == 2'd1);
			end

			if (done) begin
				scalar = acc_d;
				if ((seqlen_d == 3'd3 && scalar < MIN_3BYTE) ||
				    (seqlen_d == 3'd4 && scalar < MIN_4BYTE) ||
				    (scalar >= SURR_MIN && scalar <= SURR_MAX) ||
				    scalar > SCALAR_MAX) begin
					invalid_d = 1'b1;
				end else begin
					if (scalar <= BMP_MAX) begin
						k_units = 2'd1;
						u0      = scalar[15:0];
					end else begin
						vdiff   = scalar - MIN_4BYTE;
						k_units = 2'd2;
						u0      = {HIGH_SURR_TAG, vdiff[19:10]};
						u1      = {LOW_SURR_TAG, vdiff[9:0]};
					end
					sum = {1'b0, units_q} + {{(UNITS_W-1){1'b0}}, k_units};
					if (sum > {1'b0, limit_q}) begin
						oversize_d = 1'b1;
						u0         = 16'd0;
						u1         = 16'd0;
					end else begin
						units_d = sum[UNITS_W-1:0];
						n_units = k_units;
					end
				end
				seqlen_d = 3'd0;
				acc_d    = '0;
			end
		end
		if (final_s1) begin
			if (!invalid_d && !oversize_d && pend_d != 2'd0) begin
				invalid_d = 1'b1;
			end
			status_d = invalid_d ? ST_INVALID : (oversize_d ? ST_OVERSIZED : ST_OK);
		end
	end

	assign has_res  = final_s1 || (n_units != 2'd0);
	assign out_free = !m_valid_q || m_tready;
	assign consume  = valid_s1 && (!has_res || out_free);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[7:0];
			final_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 2'd0;
			seqlen_q   <= 3'd0;
			acc_q      <= '0;
			invalid_q  <= 1'b0;
			oversize_q <= 1'b0;
			units_q    <= '0;
		end else if (consume) begin
			if (final_s1) begin
				pend_q     <= 2'd0;
				seqlen_q   <= 3'd0;
				acc_q      <= '0;
				invalid_q  <= 1'b0;
				oversize_q <= 1'b0;
				units_q    <= '0;
			end else begin
				pend_q     <= pend_d;
				seqlen_q   <= seqlen_d;
				acc_q      <= acc_d;
				invalid_q  <= invalid_d;
				oversize_q <= oversize_d;
				units_q    <= units_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (consume && has_res) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && has_res) begin
			count_q  <= n_units;
			unit0_q  <= u0;
			unit1_q  <= u1;
			status_q <= status_d;
			last_q   <= final_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {4'd0, status_q, unit1_q, unit0_q, count_q};

endmodule

`default_nettype wire

>>> src/u2u_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder checker
// Port-level checks on the result stream, bound to the decoder top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_validating_decoder_top_defines.svh"

module u2u_checker
	import u2u_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tlast
);

	`U2U_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	`U2U_ASSERT_IMPLY(a_mid_stream_ok, clk, arst_n, m_tvalid && !m_tlast,
		m_tdata[35:34] == ST_OK && m_tdata[1:0] != 2'd0)

	`U2U_ASSERT_IMPLY(a_count_range, clk, arst_n, m_tvalid,
		m_tdata[1:0] != 2'd3 && m_tdata[35:34] != 2'd3)

	`U2U_ASSERT_IMPLY(a_pair_tags, clk, arst_n, m_tvalid && m_tdata[1:0] == 2'd2,
		m_tdata[17:12] == HIGH_SURR_TAG && m_tdata[33:28] == LOW_SURR_TAG)

endmodule

bind utf8_to_utf16_validating_decoder_top u2u_checker u_chk (.*);

`default_nettype wire

>>> dv/utf8_to_utf16_validating_decoder_top_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: stream checker
// Watches the byte stream, the unit stream and the APB port of the decoder.
// It keeps its own copy of the decode state and of unit_limit, predicts the
// UTF-16 result of every accepted byte that makes one, and compares each output
// transaction field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module utf8_to_utf16_validating_decoder_top_checker
	import u2u_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] byte_value
	input  wire logic                  s_tlast,   // final_byte
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] unit_count, [17:2] first_unit,
	                                              // [33:18] second_unit, [35:34] status
	input  wire logic                  m_tlast,   // end_of_stream
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	input  wire logic [CFG_DATA_W-1:0] prdata,
	input  wire logic                  pready,
	output int                         fail_count,
	output int                         pending_results,
	output int                         checked_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  n_units;
		logic [15:0] lead_unit;
		logic [15:0] trail_unit;
		logic        eos;
		status_t     status;
	} utf16_result_t;

	utf16_result_t expected_units[$];

	logic [LIMIT_W-1:0]  limit_q;
	logic [1:0]          conts_left;
	logic [2:0]          seq_len;
	logic [SCALAR_W-1:0] scalar_acc;
	logic                utf8_bad;
	logic                over_limit;
	logic [UNITS_W-1:0]  units_out;

	int mismatches = 0;
	int matched = 0;
	int queued = 0;

	assign fail_count      = mismatches;
	assign pending_results = queued;
	assign checked_results = matched;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < 40) begin
			$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic void clear_stream();
		conts_left = '0;
		seq_len    = '0;
		scalar_acc = '0;
		utf8_bad   = 1'b0;
		over_limit = 1'b0;
		units_out  = '0;
	endfunction

	// Advances the decode state by one byte; returns 1 when a result is due.
	function automatic bit decode_byte(input logic [7:0] b, input logic fin,
		output utf16_result_t r);
		logic [SCALAR_W-1:0] s;
		logic [SCALAR_W-1:0] v;
		logic [UNITS_W:0]    total;
		logic [1:0]          k;
		logic                done;
		r = '0;
		r.status = ST_OK;
		done = 1'b0;
		if (!utf8_bad && !over_limit) begin
			if (conts_left == 2'd0) begin
				if (b <= ASCII_MAX) begin
					scalar_acc = SCALAR_W'(b);
					seq_len = 3'd1;
					done = 1'b1;
				end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					scalar_acc = SCALAR_W'(b[4:0]);
					seq_len = 3'd2;
					conts_left = 2'd1;
				end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
					scalar_acc = SCALAR_W'(b[3:0]);
					seq_len = 3'd3;
					conts_left = 2'd2;
				end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
					scalar_acc = SCALAR_W'(b[2:0]);
					seq_len = 3'd4;
					conts_left = 2'd3;
				end else begin
					utf8_bad = 1'b1;
				end
			end else if ((b & CONT_MASK) != CONT_MARK) begin
				utf8_bad = 1'b1;
			end else begin
				scalar_acc = {scalar_acc[SCALAR_W-7:0], b[5:0]};
				conts_left = conts_left - 2'd1;
				done = (conts_left == 2'd0);
			end

			if (done) begin
				s = scalar_acc;
				if ((seq_len == 3'd3 && s < MIN_3BYTE) || (seq_len == 3'd4 && s < MIN_4BYTE) ||
					(s >= SURR_MIN && s <= SURR_MAX) || s > SCALAR_MAX) begin
					utf8_bad = 1'b1;
				end else begin
					if (s <= BMP_MAX) begin
						k = 2'd1;
						r.lead_unit = s[15:0];
					end else begin
						v = s - MIN_4BYTE;
						k = 2'd2;
						r.lead_unit  = {HIGH_SURR_TAG, v[19:10]};
						r.trail_unit = {LOW_SURR_TAG, v[9:0]};
					end
					total = {1'b0, units_out} + {{(UNITS_W-1){1'b0}}, k};
					if (total > {1'b0, limit_q}) begin
						over_limit = 1'b1;
						r.lead_unit  = '0;
						r.trail_unit = '0;
					end else begin
						units_out = total[UNITS_W-1:0];
						r.n_units = k;
					end
				end
				seq_len = '0;
				scalar_acc = '0;
			end
		end

		if (fin) begin
			if (!utf8_bad && !over_limit && conts_left != 2'd0) begin
				utf8_bad = 1'b1;
			end
			r.eos = 1'b1;
			r.status = utf8_bad ? ST_INVALID : (over_limit ? ST_OVERSIZED : ST_OK);
			clear_stream();
			return 1'b1;
		end
		return r.n_units != 2'd0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		utf16_result_t got;
		utf16_result_t want;
		utf16_result_t pred;
		if (!arst_n) begin
			limit_q = UNIT_LIMIT_RESET;
			clear_stream();
			expected_units.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.n_units    = m_tdata[1:0];
				got.lead_unit  = m_tdata[17:2];
				got.trail_unit = m_tdata[33:18];
				got.status     = status_t'(m_tdata[35:34]);
				got.eos        = m_tlast;
				if (expected_units.size() == 0) begin
					report_mismatch("unexpected result transaction", m_tdata[31:0], '0);
				end else begin
					want = expected_units.pop_front();
					if (got.n_units !== want.n_units)
						report_mismatch("unit_count", got.n_units, want.n_units);
					if (got.lead_unit !== want.lead_unit)
						report_mismatch("first_unit", got.lead_unit, want.lead_unit);
					if (got.trail_unit !== want.trail_unit)
						report_mismatch("second_unit", got.trail_unit, want.trail_unit);
					if (got.eos !== want.eos)
						report_mismatch("end_of_stream", got.eos, want.eos);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					matched++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (decode_byte(s_tdata, s_tlast, pred)) begin
					expected_units = {expected_units, pred};
				end
			end
			if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_UNIT_LIMIT) begin
				if (pwrite) begin
					limit_q = pwdata[LIMIT_W-1:0];
				end else if (prdata !== CFG_DATA_W'(limit_q)) begin
					report_mismatch("unit_limit readback", prdata, CFG_DATA_W'(limit_q));
				end
			end
		end
		queued = expected_units.size();
	end

endmodule

>>> dv/utf8_to_utf16_validating_decoder_top_test.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: testbench top
// Drives byte streams into the decoder under bursty input and a stalling
// output, and programs unit_limit over APB between phases. A short directed
// set of streams is followed by random streams, mostly well-formed with some
// carrying one encoding fault, across several limits. The checker instance
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module utf8_to_utf16_validating_decoder_top_test
	import u2u_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PHASE_BYTES  = 200;
	localparam int unsigned NUM_PHASES   = 7;
	localparam int unsigned DRAIN_CYCLES = 5000;

	typedef enum int {
		RX_STEADY,
		RX_CHOPPY,
		RX_STARVED
	} rx_mode_e;

	typedef enum int {
		F_STRAY_CONT,
		F_BAD_LEAD,
		F_HIGH_BYTE,
		F_OVERLONG3,
		F_OVERLONG4,
		F_SURROGATE,
		F_ABOVE_MAX,
		F_NO_CONT,
		F_TRUNCATED
	} fault_e;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    pending_results;
	int                    checked_results;

	logic [7:0]  stream_bytes[$];
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned streams_sent = 0;
	rx_mode_e    rx_mode = RX_STEADY;
	int unsigned rx_left = 0;

	utf8_to_utf16_validating_decoder_top i_dut (.*);

	utf8_to_utf16_validating_decoder_top_checker i_checker (.*);

	always #10 clk = ~clk;

	// output backpressure: random modes held for random stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(RX_STEADY, RX_STARVED));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		case (rx_mode)
			RX_STEADY: m_tready <= 1'b1;
			RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
			default:   m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic send_byte(input logic [7:0] value, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 256)
			                                        : $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_bytes[i]) begin
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		end
		stream_bytes.delete();
		streams_sent++;
	endtask

	task automatic wait_idle();
		int unsigned waited;
		s_tvalid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending_results != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [CFG_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {REG_UNIT_LIMIT, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic append_byte(input logic [7:0] value);
		stream_bytes = {stream_bytes, value};
	endtask

	function automatic logic [7:0] rand_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [SCALAR_W-1:0] random_scalar();
		logic [SCALAR_W-1:0] lo;
		logic [SCALAR_W-1:0] hi;
		logic [SCALAR_W-1:0] s;
		case ($urandom_range(0, 3))
			0: begin lo = 21'h0;      hi = 21'h7F;     end
			1: begin lo = 21'h80;     hi = 21'h7FF;    end
			2: begin lo = MIN_3BYTE;  hi = BMP_MAX;    end
			default: begin lo = MIN_4BYTE; hi = SCALAR_MAX; end
		endcase
		case ($urandom_range(0, 11))
			0: s = lo;
			1: s = hi;
			default: s = SCALAR_W'($urandom_range(lo, hi));
		endcase
		if (s >= SURR_MIN && s <= SURR_MAX) begin
			s = ($urandom_range(0, 1) == 0) ? SURR_MIN - 1 : SURR_MAX + 1;
		end
		return s;
	endfunction

	task automatic push_scalar(input logic [SCALAR_W-1:0] s);
		if (s <= 21'h7F) begin
			append_byte(s[7:0]);
		end else if (s <= 21'h7FF) begin
			append_byte({3'b110, s[10:6]});
			append_byte({2'b10, s[5:0]});
		end else if (s <= BMP_MAX) begin
			append_byte({4'b1110, s[15:12]});
			append_byte({2'b10, s[11:6]});
			append_byte({2'b10, s[5:0]});
		end else begin
			append_byte({5'b11110, s[20:18]});
			append_byte({2'b10, s[17:12]});
			append_byte({2'b10, s[11:6]});
			append_byte({2'b10, s[5:0]});
		end
	endtask

	// pushes a valid lead byte and some of its continuations, never all
	task automatic push_partial();
		int unsigned len;
		len = $urandom_range(2, 4);
		case (len)
			2: append_byte(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
			3: append_byte(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
			default: append_byte(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
		endcase
		repeat ($urandom_range(0, len - 2)) append_byte(rand_cont());
	endtask

	task automatic push_fault(input fault_e kind, output bit cut);
		cut = 1'b0;
		case (kind)
			F_STRAY_CONT: append_byte(rand_cont());
			F_BAD_LEAD:   append_byte(8'hC0 | 8'($urandom_range(0, 1)));
			F_HIGH_BYTE:  append_byte(8'($urandom_range(8'hF5, 8'hFF)));
			F_OVERLONG3: begin
				append_byte(LEAD3_MIN);
				append_byte(8'h80 | 8'($urandom_range(0, 31)));
				append_byte(rand_cont());
			end
			F_OVERLONG4: begin
				append_byte(LEAD4_MIN);
				append_byte(8'h80 | 8'($urandom_range(0, 15)));
				append_byte(rand_cont());
				append_byte(rand_cont());
			end
			F_SURROGATE: begin
				append_byte(8'hED);
				append_byte(8'hA0 | 8'($urandom_range(0, 31)));
				append_byte(rand_cont());
			end
			F_ABOVE_MAX: begin
				append_byte(LEAD4_MAX);
				append_byte(8'h90 + 8'($urandom_range(0, 47)));
				append_byte(rand_cont());
				append_byte(rand_cont());
			end
			F_NO_CONT: begin
				push_partial();
				if ($urandom_range(0, 1) == 0)
					append_byte(8'($urandom_range(8'h00, ASCII_MAX)));
				else
					append_byte(8'($urandom_range(8'hC0, 8'hFF)));
			end
			default: begin
				push_partial();
				cut = 1'b1;
			end
		endcase
	endtask

	// fills stream_bytes; live is the number of bytes in the stream
	task automatic build_stream(output int unsigned live);
		int unsigned n_scalars;
		int unsigned fault_pos;
		bit          has_fault;
		bit          cut;
		fault_e      kind;
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
		end else begin
			n_scalars = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 16);
			has_fault = ($urandom_range(0, 4) == 0);
			fault_pos = $urandom_range(0, n_scalars);
			kind = fault_e'($urandom_range(F_STRAY_CONT, F_TRUNCATED));
			cut = 1'b0;
			for (int i = 0; i <= n_scalars && !cut; i++) begin
				if (has_fault && i == fault_pos) begin
					push_fault(kind, cut);
				end
				if (i < n_scalars && !cut) push_scalar(random_scalar());
			end
		end
		live = stream_bytes.size();
	endtask

	initial begin
		int unsigned phase_live;
		int unsigned live;
		logic [LIMIT_W:0] phase_limit;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: boundaries of each length, four-byte at its top only, then the error cases
		stream_bytes = {8'h00};
		send_stream();
		stream_bytes = {8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
			8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_stream();
		stream_bytes = {8'hC0, 8'hE2};
		send_stream();
		stream_bytes = {8'hED, 8'hA0, 8'h80};
		send_stream();
		stream_bytes = {8'hE2, 8'h82};
		send_stream();
		stream_bytes = {8'h80};
		send_stream();

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			if (p == 0 || p == 5)
				phase_limit = 18'h10000;
			else if (p < 4)
				phase_limit = (LIMIT_W+1)'(p);
			else
				phase_limit = (LIMIT_W+1)'($urandom_range(4, 40));
			apb_access(1'b1, CFG_DATA_W'(phase_limit));
			apb_access(1'b0, '0);
			phase_live = 0;
			while (phase_live < PHASE_BYTES) begin
				build_stream(live);
				phase_live += live;
				send_stream();
			end
		end

		wait_idle();
		$display("Covered %0d bytes in %0d streams over %0d unit limits; %0d results checked.",
			bytes_sent, streams_sent, NUM_PHASES, checked_results);
		if (pending_results != 0) begin
			$display("%0d predicted results never arrived", pending_results);
		end
		if (fail_count == 0 && pending_results == 0) begin
			$display("** utf8_to_utf16_validating_decoder_top: PASSED **");
		end else begin
			$display("** utf8_to_utf16_validating_decoder_top: FAILED **");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Watchdog expired after %0d bytes", bytes_sent);
		$display("** utf8_to_utf16_validating_decoder_top: FAILED **");
		$finish;
	end

endmodule
